// ===== sv/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants for the text console with scrollback
// Screen geometry, character codes, mode codes and the transaction payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

    localparam int COLS      = 64;
    localparam int ROWS      = 32;
    localparam int HIST_ROWS = 128;

    localparam int CIDX_W  = $clog2(COLS);          // cell column index
    localparam int COL_W   = $clog2(COLS + 1);      // cursor column, COLS = wrap pending
    localparam int ROW_W   = $clog2(ROWS);
    localparam int SLOT_W  = $clog2(HIST_ROWS);
    localparam int FILL_W  = $clog2(HIST_ROWS + 1);
    localparam int SCR_AW  = ROW_W + CIDX_W;
    localparam int HIST_AW = SLOT_W + CIDX_W;
    localparam int SCR_DEPTH  = ROWS * COLS;
    localparam int HIST_DEPTH = HIST_ROWS * COLS;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [1:0] MODE_PUT     = 2'd0;
    localparam logic [1:0] MODE_RD_SCR  = 2'd1;
    localparam logic [1:0] MODE_RD_HIST = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [6:0] read_row;
        logic [5:0] read_col;
    } tcs_cmd_t;

    typedef struct packed {
        logic [7:0] cell_value;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] history_count;
        logic [6:0] history_next;
        logic       scrolled;
    } tcs_rsp_t;

endpackage

`default_nettype wire

// ===== sv/tcs_if.sv =====
// ----------------------------------------------------------------------------
// tcs_cmd_if / tcs_rsp_if: valid/ready channels of the text console
// Command channel into the console and response channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcs_cmd_if;
    import tcs_pkg::*;
    logic     valid;
    logic     ready;
    tcs_cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcs_rsp_if;
    import tcs_pkg::*;
    logic     valid;
    logic     ready;
    tcs_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/text_console_scrollback.sv =====
// ----------------------------------------------------------------------------
// text_console_scrollback: character-cell console engine with scrollback ring
// Screen RAM kept as a row ring, history RAM, cursor and scroll sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per character or cell read (mode 0 prints
//   char_code, mode 1 reads a screen cell, mode 2 reads a scrollback slot).
//   rsp returns exactly one transaction per command with the cell value
//   and the cursor / history state after the command.
//   A printed byte with no scroll is written to the screen RAM when the
//   command is taken; a read waits for the registered RAM read. A byte
//   that scrolls runs the row copy sequencer, which moves the top row
//   into history while clearing it, and a pending byte is written to the
//   fresh bottom row after the copy. The response is then loaded into the
//   output register; cmd.ready is low while the sequencer runs.
//   Reset: after rst_n rises, a clearing pass writes spaces to all 2048
//   screen cells, one per cycle, with cmd.ready low. History RAM is not
//   cleared; reading a never-written slot returns undefined data.
//   Stall: the response sits in an output register; one more command may
//   be taken into work, and the engine then waits until rsp is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_scrollback (
    input  wire logic clk,
    input  wire logic rst_n,
    tcs_cmd_if.sink   cmd,
    tcs_rsp_if.source rsp
);
    import tcs_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [7:0] screen_mem [SCR_DEPTH];
    logic [7:0] hist_mem   [HIST_DEPTH];

    logic [2:0]        state_reg,    state_next;
    logic [SCR_AW-1:0] clr_cnt_reg,  clr_cnt_next;
    logic [COL_W-1:0]  cnt_reg,      cnt_next;
    logic [COL_W-1:0]  col_reg,      col_next;
    logic [ROW_W-1:0]  line_reg,     line_next;
    logic [ROW_W-1:0]  top_reg,      top_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic              scrolled_reg, scrolled_next;
    logic              pend_reg,     pend_next;
    logic              inrange_reg,  inrange_next;
    logic [1:0]        mode_reg,     mode_next;
    logic [7:0]        ch_reg,       ch_next;
    logic [7:0]        value_reg,    value_next;
    logic              rsp_valid_reg, rsp_valid_next;
    tcs_rsp_t          rsp_reg,      rsp_next;

    logic [7:0]         scr_rd_reg;
    logic [7:0]         hist_rd_reg;
    logic [SCR_AW-1:0]  scr_raddr;
    logic [HIST_AW-1:0] hist_raddr;
    logic               scr_we;
    logic [SCR_AW-1:0]  scr_waddr;
    logic [7:0]         scr_wdata;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [CIDX_W-1:0]  hist_wcol;

    logic take;
    logic out_free;
    logic wrap;
    logic last_line;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign take      = cmd.valid && cmd.ready;
    assign wrap      = (col_reg >= COL_W'(COLS));
    assign last_line = (line_reg == ROW_W'(ROWS - 1));

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    assign scr_raddr = (state_reg == ST_SCROLL)
                     ? {top_reg, cnt_reg[CIDX_W-1:0]}
                     : {ROW_W'(top_reg + cmd.data.read_row[ROW_W-1:0]),
                        cmd.data.read_col[CIDX_W-1:0]};
    assign hist_raddr = {cmd.data.read_row[SLOT_W-1:0], cmd.data.read_col[CIDX_W-1:0]};
    assign hist_wcol  = CIDX_W'(cnt_reg - COL_W'(1));
    assign hist_waddr = {slot_reg, hist_wcol};

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        top_next       = top_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        scrolled_next  = scrolled_reg;
        pend_next      = pend_reg;
        inrange_next   = inrange_reg;
        mode_next      = mode_reg;
        ch_next        = ch_reg;
        value_next     = value_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        scr_we         = 1'b0;
        scr_waddr      = '0;
        scr_wdata      = CH_SPACE;
        hist_we        = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                scr_we       = 1'b1;
                scr_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SCR_AW'(1);
                if (clr_cnt_reg == SCR_AW'(SCR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_RDWAIT:
            begin
                if (!inrange_reg)
                begin
                    value_next = '0;
                end
                else if (mode_reg == MODE_RD_SCR)
                begin
                    value_next = scr_rd_reg;
                end
                else
                begin
                    value_next = hist_rd_reg;
                end
                state_next = ST_FINISH;
            end
            ST_SCROLL:
            begin
                // read top row cell, blank it, write previous cell to history
                if (cnt_reg < COL_W'(COLS))
                begin
                    scr_we    = 1'b1;
                    scr_waddr = {top_reg, cnt_reg[CIDX_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    hist_we = 1'b1;
                end
                cnt_next = cnt_reg + COL_W'(1);
                if (cnt_reg == COL_W'(COLS))
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                    if (fill_reg != FILL_W'(HIST_ROWS))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    top_next   = top_reg + ROW_W'(1);
                    line_next  = ROW_W'(ROWS - 1);
                    state_next = pend_reg ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                scr_we     = 1'b1;
                scr_waddr  = {ROW_W'(top_reg + line_reg), col_reg[CIDX_W-1:0]};
                scr_wdata  = ch_reg;
                col_next   = col_reg + COL_W'(1);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_next.cell_value    = value_reg;
                    rsp_next.cursor_row    = 5'(line_reg);
                    rsp_next.cursor_col    = 7'(col_reg);
                    rsp_next.history_count = 8'(fill_reg);
                    rsp_next.history_next  = 7'(slot_reg);
                    rsp_next.scrolled      = scrolled_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            mode_next     = cmd.data.mode;
            ch_next       = cmd.data.char_code;
            scrolled_next = 1'b0;
            pend_next     = 1'b0;
            value_next    = '0;
            cnt_next      = '0;
            state_next    = ST_FINISH;
            case (cmd.data.mode)
                MODE_PUT:
                begin
                    if (cmd.data.char_code == CH_NEWLINE)
                    begin
                        col_next = '0;
                        if (last_line)
                        begin
                            scrolled_next = 1'b1;
                            state_next    = ST_SCROLL;
                        end
                        else
                        begin
                            line_next = line_reg + ROW_W'(1);
                        end
                    end
                    else if (cmd.data.char_code == CH_RETURN)
                    begin
                        col_next = '0;
                    end
                    else if (cmd.data.char_code == CH_BACKSPACE)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                    end
                    else if (wrap && last_line)
                    begin
                        // scroll first, byte goes to the fresh bottom row
                        col_next      = '0;
                        pend_next     = 1'b1;
                        scrolled_next = 1'b1;
                        state_next    = ST_SCROLL;
                    end
                    else if (wrap)
                    begin
                        scr_we    = 1'b1;
                        scr_waddr = {ROW_W'(top_reg + line_reg + ROW_W'(1)), CIDX_W'(0)};
                        scr_wdata = cmd.data.char_code;
                        line_next = line_reg + ROW_W'(1);
                        col_next  = COL_W'(1);
                    end
                    else
                    begin
                        scr_we    = 1'b1;
                        scr_waddr = {ROW_W'(top_reg + line_reg), col_reg[CIDX_W-1:0]};
                        scr_wdata = cmd.data.char_code;
                        col_next  = col_reg + COL_W'(1);
                    end
                end
                MODE_RD_SCR:
                begin
                    inrange_next = (8'(cmd.data.read_row) < 8'(ROWS))
                                && (7'(cmd.data.read_col) < 7'(COLS));
                    state_next   = ST_RDWAIT;
                end
                MODE_RD_HIST:
                begin
                    inrange_next = (8'(cmd.data.read_row) < 8'(HIST_ROWS))
                                && (7'(cmd.data.read_col) < 7'(COLS));
                    state_next   = ST_RDWAIT;
                end
                default:
                begin
                    state_next = ST_FINISH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            top_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            scrolled_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            top_reg       <= top_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            scrolled_reg  <= scrolled_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inrange_reg <= inrange_next;
        mode_reg    <= mode_next;
        ch_reg      <= ch_next;
        value_reg   <= value_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        scr_rd_reg <= screen_mem[scr_raddr];
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[hist_raddr];
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= scr_rd_reg;
        end
    end

    a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.scrolled |-> rsp.data.cursor_row == 5'(ROWS - 1))
        else $error("scrolled response not on last row");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HIST_ROWS))
        else $error("history fill above ring size");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLS))
        else $error("cursor column past wrap position");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && (cnt_reg == COL_W'(COLS))
        |=> slot_reg == SLOT_W'($past(slot_reg) + SLOT_W'(1)))
        else $error("history slot did not advance after row copy");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && (cnt_reg != COL_W'(COLS))
        |=> state_reg == ST_SCROLL)
        else $error("row copy left early");

endmodule

`default_nettype wire

// ===== tb/tb_text_console_scrollback.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_scrollback: self-checking bench for the text console
// Drives print and read commands with random idle gaps on both channels,
// tracks screen, scrollback ring and cursor in a local copy of the console,
// and compares every response transaction field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_scrollback;
    import tcs_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int RAND_ITEMS   = 550;
    localparam int RAND_CAP     = 1500;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_PRINTED  = 40;

    logic clk;
    logic rst_n;

    tcs_cmd_if cmd ();
    tcs_rsp_if rsp ();

    text_console_scrollback dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int cycle_count = 0;
    always @(posedge clk) cycle_count <= cycle_count + 1;

    // console image
    logic [7:0]        screen  [ROWS][COLS];
    logic [7:0]        history [HIST_ROWS][COLS];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [SLOT_W-1:0] save_slot;
    logic [FILL_W-1:0] rows_saved;

    tcs_rsp_t due_status[$];

    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_prints = 0;
    int n_scr_reads = 0;
    int n_hist_reads = 0;
    int n_nops = 0;
    int n_scrolls = 0;
    int n_wrap_scrolls = 0;
    int src_calm = 0;
    int snk_calm = 0;

    function automatic void reset_console_image();
        int r;
        int c;
        for (r = 0; r < ROWS; r++)
            for (c = 0; c < COLS; c++)
                screen[r][c] = CH_SPACE;
        cur_col    = '0;
        cur_row    = '0;
        save_slot  = '0;
        rows_saved = '0;
    endfunction

    // next row; at the bottom the top row goes to the ring and the screen shifts up
    function automatic bit advance_line();
        int r;
        int c;
        if (cur_row == ROW_W'(ROWS - 1))
        begin
            for (c = 0; c < COLS; c++)
                history[save_slot][c] = screen[0][c];
            save_slot = (save_slot == SLOT_W'(HIST_ROWS - 1)) ? '0 : save_slot + 1'b1;
            if (rows_saved < HIST_ROWS)
                rows_saved = rows_saved + 1'b1;
            for (r = 0; r < ROWS - 1; r++)
                for (c = 0; c < COLS; c++)
                    screen[r][c] = screen[r + 1][c];
            for (c = 0; c < COLS; c++)
                screen[ROWS - 1][c] = CH_SPACE;
            n_scrolls++;
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic tcs_rsp_t predict_console(input tcs_cmd_t c);
        tcs_rsp_t r;
        r = '0;
        case (c.mode)
            MODE_PUT:
            begin
                n_prints++;
                if (c.char_code == CH_NEWLINE)
                begin
                    cur_col    = '0;
                    r.scrolled = advance_line();
                end
                else if (c.char_code == CH_RETURN)
                    cur_col = '0;
                else if (c.char_code == CH_BACKSPACE)
                begin
                    if (cur_col > 0)
                        cur_col = cur_col - 1'b1;
                end
                else
                begin
                    if (cur_col >= COLS)
                    begin
                        cur_col    = '0;
                        r.scrolled = advance_line();
                        if (r.scrolled)
                            n_wrap_scrolls++;
                    end
                    screen[cur_row][cur_col[CIDX_W-1:0]] = c.char_code;
                    cur_col = cur_col + 1'b1;
                end
            end
            MODE_RD_SCR:
            begin
                n_scr_reads++;
                if (c.read_row < ROWS && c.read_col < COLS)
                    r.cell_value = screen[c.read_row][c.read_col];
            end
            MODE_RD_HIST:
            begin
                n_hist_reads++;
                if (c.read_row < HIST_ROWS && c.read_col < COLS)
                    r.cell_value = history[c.read_row][c.read_col];
            end
            default:
                n_nops++;
        endcase
        r.cursor_row    = cur_row;
        r.cursor_col    = cur_col;
        r.history_count = rows_saved;
        r.history_next  = save_slot;
        return r;
    endfunction

    function automatic int draw_gap(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic tcs_cmd_t make_cmd(input logic [1:0] mode, input logic [7:0] ch,
                                          input logic [6:0] row, input logic [5:0] col);
        tcs_cmd_t c;
        c.mode      = mode;
        c.char_code = ch;
        c.read_row  = row;
        c.read_col  = col;
        return c;
    endfunction

    function automatic logic [7:0] random_glyph();
        logic [7:0] g;
        g = 8'($urandom_range(0, 255));
        while (g == CH_NEWLINE || g == CH_RETURN || g == CH_BACKSPACE)
            g = 8'($urandom_range(0, 255));
        return g;
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    // one command transaction; valid stays high across back-to-back commands
    task automatic send_cmd(input tcs_cmd_t c);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge clk);
        while (cmd.ready !== 1'b1)
            @(posedge clk);
        due_status.push_back(predict_console(c));
        n_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_cmd(make_cmd(MODE_PUT, ch, 7'($urandom_range(0, 127)),
                          6'($urandom_range(0, 63))));
    endtask

    task automatic read_screen(input logic [6:0] row, input logic [5:0] col);
        send_cmd(make_cmd(MODE_RD_SCR, 8'($urandom_range(0, 255)), row, col));
    endtask

    task automatic read_history(input logic [6:0] slot, input logic [5:0] col);
        send_cmd(make_cmd(MODE_RD_HIST, 8'($urandom_range(0, 255)), slot, col));
    endtask

    task automatic end_line();
        int t;
        t = $urandom_range(0, 9);
        if (t < 8)
            put_char(CH_NEWLINE);
        else if (t == 8)
            put_char(CH_RETURN);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("response %0d %s: got %0d, expected %0d",
                                   n_checked, name, got, want));
    endtask

    task automatic check_response(input tcs_rsp_t got);
        tcs_rsp_t want;
        if (due_status.size() == 0)
        begin
            report_error("response transaction with no command outstanding");
            return;
        end
        want = due_status.pop_front();
        check_field("cell_value", got.cell_value, want.cell_value);
        check_field("cursor_row", 8'(got.cursor_row), 8'(want.cursor_row));
        check_field("cursor_col", 8'(got.cursor_col), 8'(want.cursor_col));
        check_field("history_count", got.history_count, want.history_count);
        check_field("history_next", 8'(got.history_next), 8'(want.history_next));
        check_field("scrolled", 8'(got.scrolled), 8'(want.scrolled));
        n_checked++;
    endtask

    initial
    begin : response_side
        int gap;
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            gap = draw_gap(snk_calm);
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (rsp.valid !== 1'b1)
                @(posedge clk);
            check_response(rsp.data);
        end
    end

    task automatic test_reset_contents();
        read_screen(7'd0, 6'd0);
        read_screen(7'(ROWS - 1), 6'(COLS - 1));
        read_screen(7'(ROWS), 6'd0);
        read_screen(7'd127, 6'd63);
    endtask

    task automatic test_print_controls();
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        repeat (4) put_char(CH_BACKSPACE);
        put_char(8'h7F);
        read_screen(7'd0, 6'd0);
        read_screen(7'd0, 6'd1);
        put_char(8'h80);
        put_char(CH_RETURN);
        put_char(8'h42);
        put_char(CH_NEWLINE);
        read_screen(7'd0, 6'd0);
        read_screen(7'd0, 6'd2);
    endtask

    task automatic test_idle_mode();
        send_cmd(make_cmd(MODE_NOP, CH_NEWLINE, 7'd127, 6'd63));
        send_cmd(make_cmd(MODE_NOP, 8'hFF, 7'd0, 6'd0));
    endtask

    // runs of newlines and lines of random text dominate, so the screen fills, scrolls
    // and the scrollback ring wraps; reads and junk are mixed in
    task automatic test_random_traffic();
        int first;
        int pick;
        int len;
        int i;
        first = n_sent;
        while ((n_sent - first < RAND_ITEMS || n_scrolls <= HIST_ROWS)
               && n_sent - first < RAND_CAP)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                len = $urandom_range(1, 12);
                repeat (len) put_char(CH_NEWLINE);
            end
            else if (pick < 72)
            begin
                len = $urandom_range(0, 4);
                repeat (len) put_char(random_glyph());
                end_line();
            end
            else if (pick < 80)
            begin
                len = $urandom_range(58, 68);
                repeat (len) put_char(random_glyph());
                end_line();
            end
            else if (pick < 90)
            begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3 && rows_saved > 0)
                        read_history(7'(rows_saved >= HIST_ROWS ?
                                         $urandom_range(0, HIST_ROWS - 1) :
                                         $urandom_range(0, rows_saved - 1)),
                                     6'($urandom_range(0, 63)));
                    else if (pick < 7)
                        read_screen(7'(cur_row), 6'($urandom_range(0, 63)));
                    else
                        read_screen(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
                end
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        put_char(CH_BACKSPACE);
                    else if (pick == 1)
                        put_char(8'($urandom_range(0, 255)));
                    else if (pick == 2)
                        send_cmd(make_cmd(MODE_NOP, 8'($urandom_range(0, 255)),
                                          7'($urandom_range(0, 127)),
                                          6'($urandom_range(0, 63))));
                    else
                        put_char(CH_RETURN);
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd.valid = 1'b0;
        cmd.data  = '0;
        reset_console_image();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_print_controls();
        test_idle_mode();
        test_random_traffic();
        cmd.valid <= 1'b0;

        while (due_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions checked: %0d prints, %0d screen reads, %0d ring reads, %0d no-ops",
                 n_checked, n_prints, n_scr_reads, n_hist_reads, n_nops);
        $display("%0d scrolls (%0d from deferred wrap), ring holds %0d rows, %0d errors",
                 n_scrolls, n_wrap_scrolls, rows_saved, n_errors);
        if (n_errors == 0)
            $display("tb_text_console_scrollback passed");
        else
            $display("tb_text_console_scrollback failed");
        $finish;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, due_status.size());
        $display("tb_text_console_scrollback failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/tcs_pkg.sv
sv/tcs_if.sv
sv/text_console_scrollback.sv
tb/tb_text_console_scrollback.sv
